// ===== src/ptc_pkg.sv =====
// shared types and constants for the pressure and temperature compensation pipeline
// no dependencies
package ptc_pkg;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_cal;

    // request fields that ride along the pipeline
    typedef struct packed {
        logic        valid;
        logic        inv;
        logic [15:0] tcenti;
        logic [31:0] fine;
    } t_side;

    typedef enum logic [1:0] {
        REG_TEMP     = 2'd0,
        REG_PRES_LO  = 2'd1,
        REG_PRES_MID = 2'd2,
        REG_PRES_HI  = 2'd3
    } t_reg_idx;

    localparam logic [63:0] C_FINE_OFFSET = 64'd128000;
    localparam logic [20:0] C_PRES_FULL   = 21'd1048576;
    localparam logic [63:0] C_PRES_SCALE  = 64'd3125;
    localparam logic [63:0] C_CAL_ONE     = 64'h0000_8000_0000_0000;

    function automatic logic [63:0] sext16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

endpackage

// ===== src/ptc_mul64.sv =====
// two-stage multiplier giving the low 64 bits of a 64 x 64 product
// built from three 32 x 32 partial products; no dependencies
module ptc_mul64 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_ll, n_ll;
    logic [31:0] r_lh, n_lh;
    logic [31:0] r_hl, n_hl;
    logic [63:0] r_p, n_p;

    always_comb begin
        n_ll = 64'(i_a[31:0]) * 64'(i_b[31:0]);
        n_lh = i_a[31:0] * i_b[63:32];
        n_hl = i_a[63:32] * i_b[31:0];
        n_p  = r_ll + {r_lh + r_hl, 32'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_p  <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

// ===== src/ptc_temp.sv =====
// temperature front end: input register plus four stages to fine temperature,
// saturated centi-degrees and the pressure offset term; uses ptc_pkg
module ptc_temp
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [19:0] i_raw_t,
    input  logic [19:0] i_raw_p,
    input  t_cal        i_cal,
    output t_side       o_side,
    output logic [63:0] o_x1,
    output logic [19:0] o_raw_p
);
    logic [4:0]  r_vld;
    logic [19:0] r_raw_t;
    logic [19:0] r_rp [4:0];

    logic [17:0]        n_a;
    logic [16:0]        n_b;
    logic signed [33:0] n_pa_w;
    logic signed [33:0] n_pbb_w;
    logic [31:0]        r_pa, r_pbb;

    logic [31:0]        n_v1, n_bb;
    logic signed [47:0] n_pv2_w;
    logic [31:0]        r_v1, r_pv2;

    logic [31:0] n_fine, r_fine;

    logic [31:0] n_f5, n_ts;
    logic [15:0] n_tc, r_tc;
    logic [63:0] n_x1, r_x1;
    logic [31:0] r_fine_o;

    always_comb begin
        n_a     = {1'b0, r_raw_t[19:3]} - {1'b0, i_cal.t1, 1'b0};
        n_b     = {1'b0, r_raw_t[19:4]} - {1'b0, i_cal.t1};
        n_pa_w  = $signed(n_a) * $signed(i_cal.t2);
        n_pbb_w = $signed(n_b) * $signed(n_b);

        n_v1    = $signed(r_pa) >>> 11;
        n_bb    = $signed(r_pbb) >>> 12;
        n_pv2_w = $signed(n_bb) * $signed(i_cal.t3);

        n_fine  = r_v1 + 32'($signed(r_pv2) >>> 14);

        // fine * 5 + 128, wrapping in 32 bits
        n_f5 = r_fine + {r_fine[29:0], 2'b0} + 32'd128;
        n_ts = $signed(n_f5) >>> 8;
        if ($signed(n_ts) > 32'sd32767) begin
            n_tc = 16'h7fff;
        end else if ($signed(n_ts) < -32'sd32768) begin
            n_tc = 16'h8000;
        end else begin
            n_tc = n_ts[15:0];
        end
        n_x1 = {{32{r_fine[31]}}, r_fine} - C_FINE_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw_t  <= i_raw_t;
            r_rp[0]  <= i_raw_p;
            r_rp[1]  <= r_rp[0];
            r_rp[2]  <= r_rp[1];
            r_rp[3]  <= r_rp[2];
            r_rp[4]  <= r_rp[3];
            r_pa     <= n_pa_w[31:0];
            r_pbb    <= n_pbb_w[31:0];
            r_v1     <= n_v1;
            r_pv2    <= n_pv2_w[31:0];
            r_fine   <= n_fine;
            r_tc     <= n_tc;
            r_x1     <= n_x1;
            r_fine_o <= r_fine;
        end
    end

    assign o_side  = '{valid: r_vld[4], inv: 1'b0, tcenti: r_tc, fine: r_fine_o};
    assign o_x1    = r_x1;
    assign o_raw_p = r_rp[4];
endmodule

// ===== src/ptc_coef.sv =====
// pressure coefficient stages: builds the divisor and scaled numerator
// from the offset term; uses ptc_pkg and ptc_mul64
module ptc_coef
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_side       i_side,
    input  logic [63:0] i_x1,
    input  logic [19:0] i_raw_p,
    input  t_cal        i_cal,
    output t_side       o_side,
    output logic [63:0] o_num,
    output logic [63:0] o_den
);
    t_side       r_sd [7:0];
    logic [19:0] r_rp [3:0];
    logic [63:0] r_x15 [1:0];
    logic [63:0] r_x12 [1:0];

    logic [63:0] w_xx, w_x15, w_x12, w_x2a, w_xp3, w_y, w_n;
    logic [63:0] n_s, n_t, n_x2, r_s, r_t;
    logic [20:0] n_pp;
    logic [63:0] r_num, r_den;

    // phase a: x1^2, x1*p5, x1*p2
    ptc_mul64 u_mul_xx  (.i_clk, .i_en, .i_a(i_x1), .i_b(i_x1), .o_p(w_xx));
    ptc_mul64 u_mul_x15 (.i_clk, .i_en, .i_a(i_x1), .i_b(sext16(i_cal.p5)), .o_p(w_x15));
    ptc_mul64 u_mul_x12 (.i_clk, .i_en, .i_a(i_x1), .i_b(sext16(i_cal.p2)), .o_p(w_x12));
    // phase b: x1^2*p6, x1^2*p3
    ptc_mul64 u_mul_x2a (.i_clk, .i_en, .i_a(w_xx), .i_b(sext16(i_cal.p6)), .o_p(w_x2a));
    ptc_mul64 u_mul_xp3 (.i_clk, .i_en, .i_a(w_xx), .i_b(sext16(i_cal.p3)), .o_p(w_xp3));
    // phase c: divisor product and numerator scale
    ptc_mul64 u_mul_y   (.i_clk, .i_en, .i_a(r_s), .i_b({48'b0, i_cal.p1}), .o_p(w_y));
    ptc_mul64 u_mul_n   (.i_clk, .i_en, .i_a(r_t), .i_b(C_PRES_SCALE), .o_p(w_n));

    always_comb begin
        n_x2 = w_x2a + {r_x15[1][46:0], 17'b0} + (sext16(i_cal.p4) << 35);
        n_pp = C_PRES_FULL - {1'b0, r_rp[3]};
        n_t  = {12'b0, n_pp, 31'b0} - n_x2;
        n_s  = C_CAL_ONE + 64'($signed(w_xp3) >>> 8) + {r_x12[1][51:0], 12'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_sd[i].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_sd[0].valid <= i_side.valid;
            for (int i = 1; i < 8; i++) begin
                r_sd[i].valid <= r_sd[i-1].valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {r_sd[0].inv, r_sd[0].tcenti, r_sd[0].fine} <=
                {i_side.inv, i_side.tcenti, i_side.fine};
            for (int i = 1; i < 8; i++) begin
                {r_sd[i].inv, r_sd[i].tcenti, r_sd[i].fine} <=
                    {r_sd[i-1].inv, r_sd[i-1].tcenti, r_sd[i-1].fine};
            end
            r_rp[0]  <= i_raw_p;
            for (int i = 1; i < 4; i++) begin
                r_rp[i] <= r_rp[i-1];
            end
            r_x15[0] <= w_x15;
            r_x15[1] <= r_x15[0];
            r_x12[0] <= w_x12;
            r_x12[1] <= r_x12[0];
            r_s      <= n_s;
            r_t      <= n_t;
            r_num    <= w_n;
            r_den    <= 64'($signed(w_y) >>> 33);
        end
    end

    assign o_side = r_sd[7];
    assign o_num  = r_num;
    assign o_den  = r_den;
endmodule

// ===== src/ptc_div.sv =====
// pipelined signed 64-bit divider, one quotient bit per stage,
// truncating toward zero; flags a zero divisor; uses ptc_pkg
module ptc_div
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_side       i_side,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output t_side       o_side,
    output logic [63:0] o_quot
);
    localparam int W = 64;

    t_side          r_sd  [W:0];
    logic [W-1:0]   r_rem [W:0];
    logic [W-1:0]   r_nq  [W:0];
    logic [W-1:0]   r_den [W:0];
    logic           r_neg [W:0];
    t_side          r_osd;
    logic [W-1:0]   r_quot;

    // front: magnitudes and sign of the quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd[0].valid <= 1'b0;
        end else if (i_en) begin
            r_sd[0].valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0].tcenti <= i_side.tcenti;
            r_sd[0].fine   <= i_side.fine;
            r_sd[0].inv    <= (i_den == '0);
            r_rem[0]       <= '0;
            r_nq[0]        <= i_num[W-1] ? (W'(0) - i_num) : i_num;
            r_den[0]       <= i_den[W-1] ? (W'(0) - i_den) : i_den;
            r_neg[0]       <= i_num[W-1] ^ i_den[W-1];
        end
    end

    for (genvar g = 0; g < W; g++) begin : g_step
        logic [W:0] n_sh, n_dif;

        always_comb begin
            n_sh  = {r_rem[g], r_nq[g][W-1]};
            n_dif = n_sh - {1'b0, r_den[g]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[g+1].valid <= 1'b0;
            end else if (i_en) begin
                r_sd[g+1].valid <= r_sd[g].valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                {r_sd[g+1].inv, r_sd[g+1].tcenti, r_sd[g+1].fine} <=
                    {r_sd[g].inv, r_sd[g].tcenti, r_sd[g].fine};
                r_rem[g+1] <= n_dif[W] ? n_sh[W-1:0] : n_dif[W-1:0];
                r_nq[g+1]  <= {r_nq[g][W-2:0], ~n_dif[W]};
                r_den[g+1] <= r_den[g];
                r_neg[g+1] <= r_neg[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osd.valid <= 1'b0;
        end else if (i_en) begin
            r_osd.valid <= r_sd[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {r_osd.inv, r_osd.tcenti, r_osd.fine} <=
                {r_sd[W].inv, r_sd[W].tcenti, r_sd[W].fine};
            r_quot <= r_neg[W] ? (W'(0) - r_nq[W]) : r_nq[W];
        end
    end

    assign o_side = r_osd;
    assign o_quot = r_quot;
endmodule

// ===== src/pressure_temperature_compensation_top.sv =====
// top level of the pressure and temperature compensation pipeline
// depends on ptc_pkg, ptc_temp, ptc_coef, ptc_div and ptc_mul64
//
// usage:
//  - s_axis carries one request per beat: raw temperature and raw pressure
//  - m_axis returns one result per request, in order: saturated temperature
//    in 0.01 degree, fine temperature, pressure in q24.8 pascals; tuser is
//    the invalid flag, set when the pressure divisor came out zero
//  - cfg channel writes the four 48-bit calibration registers by index;
//    it is always ready and should only be used while the pipe is empty
//  - the pipe is 85 register stages deep: 5 in the temperature stages, 8 in
//    the coefficient stages, 66 in the divider (one quotient bit per stage)
//    and 6 in the final correction stages
//  - throughput is one request per cycle while the receiver does not stall;
//    every stage is a register and each 64-bit product is split into
//    registered partial products
//  - a stalled receiver freezes the whole pipe; s_axis_tready falls only
//    while a result is held and not taken, so nothing is lost or repeated
//  - reset clears all valid bits and the calibration registers to zero
module pressure_temperature_compensation_top
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // raw_temperature[19:0], raw_pressure[39:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // temperature_centi[15:0], fine_temperature[47:16],
                                       // pressure_q24_8[79:48]
    output logic        m_axis_tuser,  // pressure_invalid
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    logic        w_en;
    t_cal        w_cal;
    logic [47:0] r_cal_t, r_cal_lo, r_cal_mid, r_cal_hi;

    t_side       w_t_side, w_c_side, w_d_side;
    logic [63:0] w_x1, w_num, w_den, w_quot;
    logic [19:0] w_raw_p;

    // post-division correction
    t_side       r_sd [4:0];
    logic [63:0] r_q [3:0];
    logic [63:0] r_ps [1:0];
    logic [63:0] r_m2 [1:0];
    logic [63:0] w_ps, w_m1, w_m2, w_m3;
    logic [63:0] n_sum, r_sum, n_pres;

    logic        r_ovalid;
    logic [79:0] r_odata;
    logic        r_ouser;

    // the whole pipe moves when the output register is free or being drained
    assign w_en          = !r_ovalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t   <= '0;
            r_cal_lo  <= '0;
            r_cal_mid <= '0;
            r_cal_hi  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP:     r_cal_t   <= i_cfg_data;
                REG_PRES_LO:  r_cal_lo  <= i_cfg_data;
                REG_PRES_MID: r_cal_mid <= i_cfg_data;
                REG_PRES_HI:  r_cal_hi  <= i_cfg_data;
                default:      r_cal_t   <= r_cal_t;
            endcase
        end
    end

    assign w_cal = '{t1: r_cal_t[15:0],   t2: r_cal_t[31:16],   t3: r_cal_t[47:32],
                     p1: r_cal_lo[15:0],  p2: r_cal_lo[31:16],  p3: r_cal_lo[47:32],
                     p4: r_cal_mid[15:0], p5: r_cal_mid[31:16], p6: r_cal_mid[47:32],
                     p7: r_cal_hi[15:0],  p8: r_cal_hi[31:16],  p9: r_cal_hi[47:32]};

    ptc_temp u_temp (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_valid (s_axis_tvalid),
        .i_raw_t (s_axis_tdata[19:0]),
        .i_raw_p (s_axis_tdata[39:20]),
        .i_cal   (w_cal),
        .o_side  (w_t_side),
        .o_x1    (w_x1),
        .o_raw_p (w_raw_p)
    );

    ptc_coef u_coef (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_side  (w_t_side),
        .i_x1    (w_x1),
        .i_raw_p (w_raw_p),
        .i_cal   (w_cal),
        .o_side  (w_c_side),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    ptc_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_side (w_c_side),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_side (w_d_side),
        .o_quot (w_quot)
    );

    // ps = quotient >> 13; first round of products p9*ps and p8*p
    assign w_ps = 64'($signed(w_quot) >>> 13);

    ptc_mul64 u_mul_m1 (.i_clk, .i_en(w_en), .i_a(w_ps),   .i_b(sext16(w_cal.p9)), .o_p(w_m1));
    ptc_mul64 u_mul_m2 (.i_clk, .i_en(w_en), .i_a(w_quot), .i_b(sext16(w_cal.p8)), .o_p(w_m2));
    // second round: p9*ps*ps
    ptc_mul64 u_mul_m3 (.i_clk, .i_en(w_en), .i_a(w_m1),   .i_b(r_ps[1]),          .o_p(w_m3));

    always_comb begin
        n_sum  = r_q[3] + 64'($signed(w_m3) >>> 25) + 64'($signed(r_m2[1]) >>> 19);
        n_pres = 64'($signed(r_sum) >>> 8) + (sext16(w_cal.p7) << 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_sd[i].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_sd[0].valid <= w_d_side.valid;
            for (int i = 1; i < 5; i++) begin
                r_sd[i].valid <= r_sd[i-1].valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            {r_sd[0].inv, r_sd[0].tcenti, r_sd[0].fine} <=
                {w_d_side.inv, w_d_side.tcenti, w_d_side.fine};
            for (int i = 1; i < 5; i++) begin
                {r_sd[i].inv, r_sd[i].tcenti, r_sd[i].fine} <=
                    {r_sd[i-1].inv, r_sd[i-1].tcenti, r_sd[i-1].fine};
            end
            r_q[0]  <= w_quot;
            for (int i = 1; i < 4; i++) begin
                r_q[i] <= r_q[i-1];
            end
            r_ps[0] <= w_ps;
            r_ps[1] <= r_ps[0];
            r_m2[0] <= w_m2;
            r_m2[1] <= r_m2[0];
            r_sum   <= n_sum;
        end
    end

    // output register; sum stage valid is the last side stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= r_sd[4].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odata <= {r_sd[4].inv ? 32'b0 : n_pres[31:0], r_sd[4].fine, r_sd[4].tcenti};
            r_ouser <= r_sd[4].inv;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
endmodule

// ===== sim/pressure_temperature_compensation_top_tb.sv =====
// self-checking bench for the pressure and temperature compensation pipeline
// predicts each result from the calibration words and compares on m_axis
// depends on ptc_pkg and pressure_temperature_compensation_top
`timescale 1ns / 100ps

module pressure_temperature_compensation_top_tb;
    import ptc_pkg::*;

    typedef struct packed {
        logic        inv;
        logic [31:0] pres;
        logic [31:0] fine;
        logic [15:0] tcenti;
    } t_comp;

    // keeps the calibration copy and the queue of predicted results
    class comp_scoreboard;
        logic [47:0] cal [4];
        t_comp       pending [$];
        int          errors;

        function new();
            foreach (cal[i]) cal[i] = '0;
            errors = 0;
        endfunction

        function automatic logic [63:0] ws(logic [47:0] r, int pos);
            logic [15:0] w;
            w = r[pos +: 16];
            return {{48{w[15]}}, w};
        endfunction

        function automatic logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
            logic [63:0] an, ad, q;
            an = n[63] ? -n : n;
            ad = d[63] ? -d : d;
            q = an / ad;
            return (n[63] != d[63]) ? -q : q;
        endfunction

        function automatic t_comp compensate(logic [19:0] rt, logic [19:0] rp);
            t_comp r;
            logic [31:0] t1, t2, t3, a, b, v1, v2, fine, tt;
            logic signed [31:0] ts;
            logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic [63:0] x1, x2, p, ps, y1, y2;
            t1 = {16'd0, cal[REG_TEMP][15:0]};
            t2 = 32'(ws(cal[REG_TEMP], 16));
            t3 = 32'(ws(cal[REG_TEMP], 32));
            p1 = {48'd0, cal[REG_PRES_LO][15:0]};
            p2 = ws(cal[REG_PRES_LO], 16);
            p3 = ws(cal[REG_PRES_LO], 32);
            p4 = ws(cal[REG_PRES_MID], 0);
            p5 = ws(cal[REG_PRES_MID], 16);
            p6 = ws(cal[REG_PRES_MID], 32);
            p7 = ws(cal[REG_PRES_HI], 0);
            p8 = ws(cal[REG_PRES_HI], 16);
            p9 = ws(cal[REG_PRES_HI], 32);
            // temperature chain wraps at 32 bits
            a = {15'd0, rt[19:3]} - (t1 << 1);
            v1 = $signed(a * t2) >>> 11;
            b = {16'd0, rt[19:4]} - t1;
            v2 = $signed(32'($signed(b * b) >>> 12) * t3) >>> 14;
            fine = v1 + v2;
            tt = fine * 32'd5 + 32'd128;
            ts = $signed(tt) >>> 8;
            if (ts > 32767) r.tcenti = 16'h7fff;
            else if (ts < -32768) r.tcenti = 16'h8000;
            else r.tcenti = ts[15:0];
            r.fine = fine;
            // pressure chain wraps at 64 bits
            x1 = {{32{fine[31]}}, fine} - 64'd128000;
            x2 = x1 * x1 * p6;
            x2 = x2 + ((x1 * p5) << 17);
            x2 = x2 + (p4 << 35);
            x1 = 64'($signed(x1 * x1 * p3) >>> 8) + ((x1 * p2) << 12);
            x1 = $signed(((64'd1 << 47) + x1) * p1) >>> 33;
            r.inv = (x1 == 0);
            r.pres = '0;
            if (!r.inv) begin
                p = 64'd1048576 - {44'd0, rp};
                p = sdiv(((p << 31) - x2) * 64'd3125, x1);
                ps = $signed(p) >>> 13;
                y1 = $signed(p9 * ps * ps) >>> 25;
                y2 = $signed(p8 * p) >>> 19;
                p = 64'($signed(p + y1 + y2) >>> 8) + (p7 << 4);
                r.pres = p[31:0];
            end
            return r;
        endfunction

        function void note_request(logic [39:0] d);
            pending.push_back(compensate(d[19:0], d[39:20]));
        endfunction

        function void check_result(logic [79:0] d, logic u);
            t_comp e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.tcenti) begin
                $display("%0t: temperature exp %h got %h", $time, e.tcenti, d[15:0]);
                errors++;
            end
            if (d[47:16] !== e.fine) begin
                $display("%0t: fine exp %h got %h", $time, e.fine, d[47:16]);
                errors++;
            end
            if (d[79:48] !== e.pres) begin
                $display("%0t: pressure exp %h got %h", $time, e.pres, d[79:48]);
                errors++;
            end
            if (u !== e.inv) begin
                $display("%0t: invalid exp %b got %b", $time, e.inv, u);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 85;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    comp_scoreboard sb = new();

    // receiver control: random stalls, a forced long hold-off, none at the end
    bit quiet_sink = 1'b0;
    bit hold_sink = 1'b0;
    bit rand_gaps = 1'b1;

    pressure_temperature_compensation_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check every accepted result, stall in random bursts
    always @(posedge i_clk) begin
        int gap;
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (hold_sink) begin
            m_axis_tready <= 1'b0;
        end else if (!quiet_sink && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 19);
            m_axis_tready <= 1'b0;
            repeat (gap) @(posedge i_clk) begin
                if (m_axis_tvalid && m_axis_tready)
                    sb.check_result(m_axis_tdata, m_axis_tuser);
            end
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one request on s_axis; optional idle burst before it
    task automatic send_request(logic [19:0] rt, logic [19:0] rp);
        if (rand_gaps && $urandom_range(0, 11) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rp, rt};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request({rp, rt});
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_cal(t_reg_idx idx, logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.cal[idx] = val;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rnd16();
        logic [15:0] w;
        w = 16'($urandom);
        return w;
    endfunction

    // calibration near the sensor's typical trim, with random spread
    task automatic write_typical_cal();
        write_cal(REG_TEMP, {16'(50 + $urandom_range(0, 20)),
            16'(26000 + $urandom_range(0, 2000)), 16'(27000 + $urandom_range(0, 2000))});
        write_cal(REG_PRES_LO, {16'(6000 + $urandom_range(0, 200)),
            16'(-16'sd10700 + $urandom_range(0, 400)), 16'(36000 + $urandom_range(0, 2000))});
        write_cal(REG_PRES_MID, {16'(-16'sd7 - $urandom_range(0, 3)),
            16'(-16'sd40 + $urandom_range(0, 100)), 16'(2800 + $urandom_range(0, 200))});
        write_cal(REG_PRES_HI, {16'(4000 + $urandom_range(0, 1000)),
            16'(-16'sd14600 + $urandom_range(0, 400)), 16'(15 + $urandom_range(0, 5))});
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_request(20'($urandom), 20'($urandom));
            else
                send_request(20'(400000 + $urandom_range(0, 300000)),
                             20'(300000 + $urandom_range(0, 300000)));
        end
    endtask

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: divisor zero so every result is invalid
        send_request('0, '0);
        send_request('1, '1);
        drain_pipe();

        // extremes of the calibration words
        write_cal(REG_TEMP, 48'hffff_ffff_ffff);
        write_cal(REG_PRES_LO, 48'hffff_ffff_ffff);
        write_cal(REG_PRES_MID, 48'hffff_ffff_ffff);
        write_cal(REG_PRES_HI, 48'hffff_ffff_ffff);
        send_request('0, '0);
        send_request('1, '1);
        send_request(20'h80000, 20'h7ffff);
        drain_pipe();
        write_cal(REG_TEMP, 48'h8000_7fff_0000);
        write_cal(REG_PRES_LO, 48'h8000_8000_ffff);
        write_cal(REG_PRES_MID, 48'h7fff_7fff_7fff);
        write_cal(REG_PRES_HI, 48'h8000_8000_8000);
        send_request('1, '0);
        send_request('0, '1);
        send_request(20'h55555, 20'haaaaa);
        drain_pipe();
        // large positive t2 and t3 with raw temperature at both extremes
        write_cal(REG_TEMP, 48'h7fff_7fff_0001);
        send_request('1, 20'h12345);
        send_request('0, 20'h54321);
        drain_pipe();

        // typical trim, random content
        write_typical_cal();
        random_burst(300);

        // receiver holds off long enough to fill the pipe and stall s_axis
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            random_burst(150);
        join
        drain_pipe();

        // random calibration words, noise included
        write_cal(REG_TEMP, {rnd16(), rnd16(), rnd16()});
        write_cal(REG_PRES_LO, {rnd16(), rnd16(), rnd16()});
        write_cal(REG_PRES_MID, {rnd16(), rnd16(), rnd16()});
        write_cal(REG_PRES_HI, {rnd16(), rnd16(), rnd16()});
        random_burst(200);
        drain_pipe();

        // last part: no idling on either side
        write_typical_cal();
        rand_gaps = 1'b0;
        quiet_sink = 1'b1;
        random_burst(420);
        drain_pipe();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
